// ===== rtl/bese_pkg.sv =====
// Shared constants and types for the binary erosion unit.
// Used by the front end, queue, window engine and top level; depends on nothing.
`default_nettype none

package bese_pkg;

  // Default build limits.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int MAX_ELEMENT_DEF = 7;

  // Element mask layout: one row of the element every seven bits.
  localparam int MASK_STRIDE = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 49;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_FOREGROUND = 3'd4;

  // Register widths and reset values.
  localparam int DIM_CFG_W  = 11;
  localparam int SIZE_CFG_W = 3;
  localparam int MASK_W     = 49;

  localparam logic [DIM_CFG_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_CFG_W-1:0]  IMAGE_HEIGHT_RST = 11'd1024;
  localparam logic [SIZE_CFG_W-1:0] ELEMENT_SIZE_RST = 3'd3;
  localparam logic [MASK_W-1:0]     ELEMENT_MASK_RST = {MASK_W{1'b1}};

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Pixel levels.
  localparam logic [7:0] PIX_LOW  = 8'd0;
  localparam logic [7:0] PIX_HIGH = 8'd255;

  // Control part of one shift operation sent from front to back.
  typedef struct packed {
    logic pix_bit;
    logic emit;
    logic last;
  } op_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bese_front.sv =====
// Front end of the erosion unit: accepts items, tracks the frame position
// and turns each item into line-buffer shift operations. Uses bese_pkg.
`default_nettype none

module bese_front import bese_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_ELEMENT = MAX_ELEMENT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                restart,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]     h,
  input  wire logic [$clog2(MAX_ELEMENT+1)-1:0]    lag,
  input  wire logic [7:0]                          fg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_command,
  input  wire logic [7:0]                          in_pixel_value,
  input  wire logic                                q_room,
  output logic                                     push,
  output op_ctl_t                                  push_ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]             push_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]            push_y,
  output logic [$clog2(MAX_WIDTH)-1:0]             push_x
);

  localparam int DIM_W  = $clog2(MAX_WIDTH+1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT+1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int T_W    = $clog2(MAX_ELEMENT*(MAX_WIDTH+1)+2);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PAD  = 1'b1;

  logic              state_r, state_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [HDIM_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  vcol_r, vcol_nxt;
  logic [T_W-1:0]    t_r, t_nxt;
  logic [T_W-1:0]    lag_len;

  // Shifts that must precede the first result: lag rows plus lag pixels plus one.
  assign lag_len = T_W'(lag) * T_W'(w) + T_W'(lag) + T_W'(1);

  assign in_ready = (state_r == ST_IDLE) && q_room;

  assign push_col = vcol_r;
  assign push_y   = out_row_r;
  assign push_x   = out_col_r;

  // Frame bookkeeping and shift generation.
  always_comb begin
    logic              in_full;
    logic              started;
    logic              is_pixel;
    logic              wr;
    logic              fg_bit;
    logic [DIM_W-1:0]  in_col_p1;
    logic [HDIM_W-1:0] in_row_p1;
    logic [COL_W-1:0]  col_wr;
    logic [HDIM_W-1:0] row_wr;
    logic              full_after;
    logic [T_W-1:0]    t_after;
    logic [T_W-1:0]    t_p1;
    logic              emit_need;
    logic              hit;
    logic              is_last;
    logic [DIM_W-1:0]  vcol_p1;
    logic [DIM_W-1:0]  out_col_p1;
    logic [HDIM_W-1:0] out_row_p1;

    state_nxt   = state_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    vcol_nxt    = vcol_r;
    t_nxt       = t_r;
    push        = 1'b0;
    push_ctl    = '0;

    in_full   = in_row_r >= h;
    started   = (in_row_r != '0) || (in_col_r != '0);
    is_pixel  = in_command == CMD_PIXEL;
    wr        = !in_full && (is_pixel || started);
    fg_bit    = is_pixel && (in_pixel_value == fg);
    in_col_p1 = DIM_W'(in_col_r) + DIM_W'(1);
    in_row_p1 = in_row_r + HDIM_W'(1);
    if (in_col_p1 >= w) begin
      col_wr = '0;
      row_wr = in_row_p1;
    end else begin
      col_wr = in_col_p1[COL_W-1:0];
      row_wr = in_row_r;
    end
    full_after = wr ? (row_wr >= h) : in_full;
    t_after    = t_r + T_W'(wr);
    t_p1       = t_r + T_W'(1);
    emit_need  = full_after || (t_after >= lag_len);
    hit        = t_p1 == lag_len;
    out_col_p1 = DIM_W'(out_col_r) + DIM_W'(1);
    out_row_p1 = HDIM_W'(out_row_r) + HDIM_W'(1);
    is_last    = (out_col_p1 == w) && (out_row_p1 == h);
    vcol_p1    = DIM_W'(vcol_r) + DIM_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (wr) begin
            in_col_nxt = col_wr;
            in_row_nxt = row_wr;
          end
          if (wr || emit_need) begin
            push             = 1'b1;
            push_ctl.pix_bit = wr && fg_bit;
            push_ctl.emit    = emit_need && hit;
            if (emit_need && !hit) begin
              state_nxt = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        // Background shifts until the window lines up with the next result.
        if (q_room) begin
          push          = 1'b1;
          push_ctl.emit = hit;
          if (hit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    push_ctl.last = push_ctl.emit && is_last;

    // Every push is one shift; a result advances the output position.
    if (push) begin
      t_nxt    = t_p1;
      vcol_nxt = (vcol_p1 >= w) ? '0 : vcol_p1[COL_W-1:0];
      if (push_ctl.emit) begin
        t_nxt = t_r;
        if (out_col_p1 >= w) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_p1[ROW_W-1:0];
        end else begin
          out_col_nxt = out_col_p1[COL_W-1:0];
        end
        if (is_last) begin
          state_nxt   = ST_IDLE;
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          vcol_nxt    = '0;
          t_nxt       = '0;
        end
      end
    end
  end

  // Control registers; a geometry write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r   <= ST_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      vcol_r    <= '0;
      t_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      vcol_r    <= vcol_nxt;
      t_r       <= t_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bese_queue.sv =====
// Short FIFO between the front end and the window engine.
// Generic data width; uses bese_pkg only for house conventions.
`default_nettype none

module bese_queue import bese_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   room,
  input  wire logic              pop,
  output logic                   pop_valid,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign room      = cnt_r != CNT_W'(DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_data  = slot_r[rptr_r];
  assign do_push   = push && room;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH-1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH-1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bese_back.sv =====
// Window engine of the erosion unit: line buffer memory, sliding window
// register and the element fit test with output register. Uses bese_pkg.
`default_nettype none

module bese_back import bese_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_ELEMENT = MAX_ELEMENT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    w,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   h,
  input  wire logic [$clog2(MAX_ELEMENT+1)-1:0]  s,
  input  wire logic [MASK_W-1:0]                 mask,
  input  wire logic                              dark,
  input  wire logic                              q_valid,
  output logic                                   pop,
  input  wire op_ctl_t                           q_ctl,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      q_col,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]     q_y,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      q_x,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_pixel,
  output logic                                   out_frame_last
);

  localparam int DIM_W  = $clog2(MAX_WIDTH+1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT+1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = $clog2(MAX_ELEMENT+1);
  localparam int IDX_W  = (MAX_ELEMENT > 1) ? $clog2(MAX_ELEMENT) : 1;
  localparam int LB_W   = (MAX_ELEMENT > 1) ? MAX_ELEMENT - 1 : 1;
  localparam int YW     = HDIM_W + 1;
  localparam int XW     = DIM_W + 1;

  logic                   en;
  logic [LB_W-1:0]        lb_mem [MAX_WIDTH];
  logic [LB_W-1:0]        rd_r;
  logic                   s1_valid_r;
  op_ctl_t                s1_ctl_r;
  logic [COL_W-1:0]       s1_col_r;
  logic [ROW_W-1:0]       s1_y_r;
  logic [COL_W-1:0]       s1_x_r;
  logic [MAX_ELEMENT-1:0] colv;
  logic [LB_W-1:0]        lb_wr;
  logic [MAX_ELEMENT-1:0] win_r [MAX_ELEMENT];
  logic                   s2_valid_r;
  op_ctl_t                s2_ctl_r;
  logic [ROW_W-1:0]       s2_y_r;
  logic [COL_W-1:0]       s2_x_r;
  logic                   fit;
  logic                   out_valid_r;
  logic [7:0]             out_pixel_r;
  logic                   out_last_r;

  // The whole pipeline moves when the output register is free or taken.
  assign en  = !out_valid_r || out_ready;
  assign pop = en && q_valid;

  // New window column: this pixel's bit over the rows above it.
  always_comb begin
    colv    = '0;
    lb_wr   = '0;
    colv[0] = s1_ctl_r.pix_bit;
    for (int k = 1; k < MAX_ELEMENT; k++) begin
      colv[k] = rd_r[k-1];
    end
    for (int k = 0; k < LB_W; k++) begin
      if (k < MAX_ELEMENT) begin
        lb_wr[k] = colv[k];
      end
    end
  end

  // Line buffer: one column word per image column, read ahead at pop time.
  always_ff @(posedge clk) begin
    if (en && s1_valid_r) begin
      lb_mem[s1_col_r] <= lb_wr;
    end
    if (pop) begin
      if (s1_valid_r && (s1_col_r == q_col)) begin
        rd_r <= lb_wr;
      end else begin
        rd_r <= lb_mem[q_col];
      end
    end
  end

  // Stage valids and the window shift register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int j = 0; j < MAX_ELEMENT; j++) begin
        win_r[j] <= '0;
      end
    end else if (en) begin
      s1_valid_r <= q_valid;
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        win_r[0] <= colv;
        for (int j = 1; j < MAX_ELEMENT; j++) begin
          win_r[j] <= win_r[j-1];
        end
      end
    end
  end

  // Operation fields that travel along with the valids.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ctl_r <= q_ctl;
      s1_col_r <= q_col;
      s1_y_r   <= q_y;
      s1_x_r   <= q_x;
    end
    if (en && s1_valid_r) begin
      s2_ctl_r <= s1_ctl_r;
      s2_y_r   <= s1_y_r;
      s2_x_r   <= s1_x_r;
    end
  end

  // Fit test: every used element position must land in the image on a set bit.
  always_comb begin
    logic [SIZE_W-1:0]      off;
    logic [MAX_ELEMENT-1:0] row_ok;
    logic [MAX_ELEMENT-1:0] col_ok;
    logic [YW-1:0]          yv;
    logic [XW-1:0]          xv;
    logic [SIZE_W-1:0]      kk;
    logic [SIZE_W-1:0]      jj;
    logic                   used;
    logic                   hit_bit;

    off = s >> 1;
    fit = 1'b1;
    for (int r = 0; r < MAX_ELEMENT; r++) begin
      yv        = YW'(s2_y_r) + YW'(r);
      row_ok[r] = (yv >= YW'(off)) && (yv < YW'(h) + YW'(off));
    end
    for (int c = 0; c < MAX_ELEMENT; c++) begin
      xv        = XW'(s2_x_r) + XW'(c);
      col_ok[c] = (xv >= XW'(off)) && (xv < XW'(w) + XW'(off));
    end
    for (int r = 0; r < MAX_ELEMENT; r++) begin
      for (int c = 0; c < MAX_ELEMENT; c++) begin
        used    = (SIZE_W'(r) < s) && (SIZE_W'(c) < s) && mask[r*MASK_STRIDE+c];
        kk      = s - SIZE_W'(1) - SIZE_W'(r);
        jj      = s - SIZE_W'(1) - SIZE_W'(c);
        hit_bit = 1'b1;
        if (used) begin
          hit_bit = row_ok[r] && col_ok[c] && win_r[jj[IDX_W-1:0]][kk[IDX_W-1:0]];
        end
        fit = fit && hit_bit;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid_r && s2_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid_r) begin
      out_pixel_r <= (fit != dark) ? PIX_HIGH : PIX_LOW;
      out_last_r  <= s2_ctl_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/binary_erosion_structuring_element_unit.sv =====
// Top level of the streaming binary erosion unit: configuration registers,
// front end, operation queue and window engine. Uses bese_pkg, bese_front, bese_queue and bese_back.
//
//   Channel | Direction | Handshake          | Beat contents
//   in_     | input     | in_valid/in_ready  | in_command, in_pixel_value
//   out_    | output    | out_valid/out_ready| out_pixel, out_frame_last
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One input beat is taken per cycle while in_ready is high; a result is offered once the
// beat that completes its window has passed the queue, the line buffer read stage, the
// window stage and the output register.
// For frames smaller than the element lag the front end inserts padding
// shifts, one per cycle while the queue has room, and holds in_ready low until they are done.
// Reset is synchronous and active low; the line buffer needs no clearing pass.
// A stalled output holds the whole window engine; the queue absorbs four shifts.
`default_nettype none

module binary_erosion_structuring_element_unit import bese_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_ELEMENT = MAX_ELEMENT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [7:0]            in_pixel_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_pixel,
  output logic                       out_frame_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_W  = $clog2(MAX_WIDTH+1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT+1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = $clog2(MAX_ELEMENT+1);
  localparam int OP_W   = $bits(op_ctl_t) + COL_W + ROW_W + COL_W;

  logic [DIM_CFG_W-1:0]  width_r;
  logic [DIM_CFG_W-1:0]  height_r;
  logic [SIZE_CFG_W-1:0] size_r;
  logic [MASK_W-1:0]     mask_r;
  logic                  dark_r;
  logic                  restart;
  logic [DIM_W-1:0]      w_c;
  logic [HDIM_W-1:0]     h_c;
  logic [SIZE_W-1:0]     s_c;
  logic [SIZE_W-1:0]     lag;
  logic [7:0]            fg;

  logic                  push;
  op_ctl_t               push_ctl;
  logic [COL_W-1:0]      push_col;
  logic [ROW_W-1:0]      push_y;
  logic [COL_W-1:0]      push_x;
  logic                  q_room;
  logic                  q_valid;
  logic                  pop;
  logic [OP_W-1:0]       q_data;
  op_ctl_t               q_ctl;
  logic [COL_W-1:0]      q_col;
  logic [ROW_W-1:0]      q_y;
  logic [COL_W-1:0]      q_x;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
      size_r   <= ELEMENT_SIZE_RST;
      mask_r   <= ELEMENT_MASK_RST;
      dark_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:     width_r  <= cfg_data[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT:    height_r <= cfg_data[DIM_CFG_W-1:0];
        REG_ELEMENT_SIZE:    size_r   <= cfg_data[SIZE_CFG_W-1:0];
        REG_ELEMENT_MASK:    mask_r   <= cfg_data[MASK_W-1:0];
        REG_DARK_FOREGROUND: dark_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Geometry writes restart the frame.
  assign restart = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                              (cfg_index == REG_IMAGE_HEIGHT) ||
                              (cfg_index == REG_ELEMENT_SIZE));

  // Clamp the geometry into its legal range: zero acts as one.
  always_comb begin
    logic [31:0] wx, hx, sx;
    wx = 32'(width_r);
    hx = 32'(height_r);
    sx = 32'(size_r);
    if (wx == 32'd0)            w_c = DIM_W'(1);
    else if (wx > MAX_WIDTH)    w_c = DIM_W'(MAX_WIDTH);
    else                        w_c = DIM_W'(wx);
    if (hx == 32'd0)            h_c = HDIM_W'(1);
    else if (hx > MAX_HEIGHT)   h_c = HDIM_W'(MAX_HEIGHT);
    else                        h_c = HDIM_W'(hx);
    if (sx == 32'd0)            s_c = SIZE_W'(1);
    else if (sx > MAX_ELEMENT)  s_c = SIZE_W'(MAX_ELEMENT);
    else                        s_c = SIZE_W'(sx);
  end

  assign lag = s_c - SIZE_W'(1) - (s_c >> 1);
  assign fg  = dark_r ? PIX_LOW : PIX_HIGH;

  bese_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_ELEMENT (MAX_ELEMENT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (restart),
    .w              (w_c),
    .h              (h_c),
    .lag            (lag),
    .fg             (fg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_pixel_value (in_pixel_value),
    .q_room         (q_room),
    .push           (push),
    .push_ctl       (push_ctl),
    .push_col       (push_col),
    .push_y         (push_y),
    .push_x         (push_x)
  );

  bese_queue #(
    .DATA_W (OP_W),
    .DEPTH  (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_col, push_y, push_x}),
    .room      (q_room),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  assign {q_ctl, q_col, q_y, q_x} = q_data;

  bese_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_ELEMENT (MAX_ELEMENT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .w              (w_c),
    .h              (h_c),
    .s              (s_c),
    .mask           (mask_r),
    .dark           (dark_r),
    .q_valid        (q_valid),
    .pop            (pop),
    .q_ctl          (q_ctl),
    .q_col          (q_col),
    .q_y            (q_y),
    .q_x            (q_x),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

// ===== rtl/bese_checker.sv =====
// Port-level checks for the erosion unit and the bind that attaches them.
// Depends on binary_erosion_structuring_element_unit port names.
`default_nettype none

module bese_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_pixel,
  input wire logic       out_frame_last
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_frame_last))
    else $error("result beat changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Results are always one of the two binary levels.
  a_binary_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel == 8'd0 || out_pixel == 8'd255))
    else $error("result pixel is not a binary level");

endmodule

bind binary_erosion_structuring_element_unit bese_checker u_bese_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pixel      (out_pixel),
  .out_frame_last (out_frame_last)
);

`default_nettype wire
